@@ hw/rtl/buddy_allocator_core_defines.svh @@
// Assertion macros for the checker of the buddy allocator.
`ifndef BUDDY_ALLOCATOR_CORE_DEFINES_SVH
`define BUDDY_ALLOCATOR_CORE_DEFINES_SVH

// Asserts that an antecedent implies a consequent in the same cycle.
`define BA_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Asserts that an antecedent implies a consequent in the next cycle.
`define BA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

@@ hw/rtl/ba_pkg.sv @@
// Package with the node codes, commands, status codes and controller states.
package ba_pkg;

  typedef enum logic [1:0] {
    ND_EMPTY      = 2'd0,
    ND_FULL_LEAF  = 2'd1,
    ND_SPLIT      = 2'd2,
    ND_SPLIT_FULL = 2'd3
  } node_t;

  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NO_SPACE  = 2'd1;
  localparam logic [1:0] ST_NOT_FOUND = 2'd2;

  localparam logic [23:0] BLOCK_BASE = 24'hF00000;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_RD,
    S_EVAL,
    S_SPLIT,
    S_UP_RD,
    S_UP_RD2,
    S_UP_EVAL,
    S_DONE
  } fsm_t;

  function automatic logic is_full(input logic [1:0] s);
    return (s == ND_FULL_LEAF) || (s == ND_SPLIT_FULL);
  endfunction

  function automatic logic [1:0] merge(input logic [1:0] l, input logic [1:0] r);
    if (is_full(l) && is_full(r)) return ND_SPLIT_FULL;
    else if (l != ND_EMPTY || r != ND_EMPTY) return ND_SPLIT;
    else return ND_EMPTY;
  endfunction

endpackage

@@ hw/rtl/buddy_allocator_core.sv @@
// Top level of the binary buddy allocator with its node memory and controller.
//
// Usage: pulse start with in_command, in_alloc_size and in_free_address while
// busy is low. The request is taken at that edge and busy rises. When the
// walk ends, out_valid is high for one cycle with out_block_address,
// out_status and out_bytes_in_use. The receiver cannot stall the output.
// Each tree level is walked going down by read, decide and possibly split
// states, and going back up by two child reads and a merge; the depth is
// up to POOL_LOG2_MAX - MIN_BLOCK_LOG2, and a failed allocation backtracks
// through the tree and may take longer. One request is in flight at a time.
// Reset and any cfg write clear all 2^(POOL_LOG2_MAX - MIN_BLOCK_LOG2 + 1)
// entries of the node memory one entry a cycle, while busy stays high, and
// zero the byte count. Configuration is written only while idle.
module buddy_allocator_core
  import ba_pkg::*;
#(
  parameter int POOL_LOG2_MAX  = 20,
  parameter int MIN_BLOCK_LOG2 = 5
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic        in_command,
  input  logic [21:0] in_alloc_size,
  input  logic [23:0] in_free_address,
  input  logic        cfg_we,
  input  logic [4:0]  cfg_wdata,
  output logic        out_valid,
  output logic [23:0] out_block_address,
  output logic [1:0]  out_status,
  output logic [20:0] out_bytes_in_use
);

  localparam int LEVELS = POOL_LOG2_MAX - MIN_BLOCK_LOG2;
  localparam int AW     = LEVELS + 1;
  localparam int DW     = (LEVELS < 1) ? 1 : $clog2(LEVELS + 1);

  logic [1:0] mem [2**AW];
  logic [AW-1:0] ra, wa;
  logic [1:0] rd_q, wd;
  logic we;

  always_ff @(posedge clk) begin
    if (we) mem[wa] <= wd;
    rd_q <= mem[ra];
  end

  fsm_t st_r, st_nxt;
  logic [AW-1:0] node_r, node_nxt;
  logic [AW-1:0] clr_r, clr_nxt;
  logic [DW-1:0] dep_r, dep_nxt;
  logic [LEVELS:0] path_r, path_nxt;
  logic [LEVELS:0] tried_r, tried_nxt;
  logic [4:0] pool_r, pool_nxt;
  logic [4:0] p_r, p_nxt;
  logic [4:0] k_r, k_nxt;
  logic cmd_r, cmd_nxt;
  logic [23:0] addr_r, addr_nxt;
  logic [23:0] base_r, base_nxt;
  logic [20:0] bytes_r, bytes_nxt;
  logic ok_r, ok_nxt;
  logic [1:0] lch_r, lch_nxt;
  logic [1:0] stat_r, stat_nxt;

  logic [4:0] pc, kc, s_cur;
  logic [23:0] half;
  logic [24:0] hi_end;

  always_comb begin
    pc = cfg_wdata < 5'(MIN_BLOCK_LOG2) ? 5'(MIN_BLOCK_LOG2) :
         cfg_wdata > 5'(POOL_LOG2_MAX) ? 5'(POOL_LOG2_MAX) : cfg_wdata;
    kc = 5'(MIN_BLOCK_LOG2);
    for (int j = MIN_BLOCK_LOG2; j < 24; j++) begin
      if (5'(j) < pool_r && (22'd1 << j) < in_alloc_size && 5'(j) == kc) kc = 5'(j + 1);
    end
  end

  assign s_cur  = p_r - 5'(dep_r);
  assign half   = (s_cur == 5'd0) ? 24'd0 : (24'd1 << (s_cur - 5'd1));
  assign hi_end = {1'b0, BLOCK_BASE} + {1'b0, base_r} + {1'b0, half};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r    <= S_CLEAR;
      clr_r   <= '0;
      pool_r  <= 5'(POOL_LOG2_MAX);
      bytes_r <= '0;
    end else begin
      st_r    <= st_nxt;
      clr_r   <= clr_nxt;
      pool_r  <= pool_nxt;
      bytes_r <= bytes_nxt;
    end
    node_r  <= node_nxt;
    dep_r   <= dep_nxt;
    path_r  <= path_nxt;
    tried_r <= tried_nxt;
    p_r     <= p_nxt;
    k_r     <= k_nxt;
    cmd_r   <= cmd_nxt;
    addr_r  <= addr_nxt;
    base_r  <= base_nxt;
    ok_r    <= ok_nxt;
    lch_r   <= lch_nxt;
    stat_r  <= stat_nxt;
  end

  always_comb begin
    logic [AW-1:0] par;
    st_nxt = st_r; clr_nxt = clr_r; pool_nxt = pool_r; bytes_nxt = bytes_r;
    node_nxt = node_r; dep_nxt = dep_r; path_nxt = path_r; tried_nxt = tried_r;
    p_nxt = p_r; k_nxt = k_r; cmd_nxt = cmd_r; addr_nxt = addr_r;
    base_nxt = base_r; ok_nxt = ok_r; lch_nxt = lch_r; stat_nxt = stat_r;
    ra = node_r; wa = node_r; wd = ND_EMPTY; we = 1'b0;
    par = (node_r - AW'(1)) >> 1;
    busy = (st_r != S_IDLE);
    out_valid = 1'b0;
    out_block_address = (cmd_r == CMD_ALLOC && ok_r) ? BLOCK_BASE + base_r : 24'd0;
    out_status = stat_r;
    out_bytes_in_use = bytes_r;
    unique case (st_r)
      S_CLEAR: begin
        we = 1'b1; wa = clr_r; wd = ND_EMPTY;
        clr_nxt = clr_r + 1'b1;
        if (clr_r == '1) st_nxt = S_IDLE;
      end
      S_IDLE: begin
        p_nxt = pool_r;
        if (cfg_we) begin
          pool_nxt = pc; bytes_nxt = '0; clr_nxt = '0; st_nxt = S_CLEAR;
        end else if (start) begin
          cmd_nxt = in_command; addr_nxt = in_free_address;
          k_nxt = kc; node_nxt = '0; dep_nxt = '0; base_nxt = '0;
          ok_nxt = 1'b0; tried_nxt = '0; path_nxt = '0;
          if (in_command == CMD_ALLOC && {2'b0, in_alloc_size} > (24'd1 << pool_r)) begin
            stat_nxt = ST_NO_SPACE; st_nxt = S_DONE;
          end else begin
            ra = '0; st_nxt = S_EVAL;
          end
        end
      end
      S_RD: begin
        ra = node_r; st_nxt = S_EVAL;
      end
      S_EVAL: begin
        if (cmd_r == CMD_ALLOC) begin
          if (is_full(rd_q) || (rd_q == ND_EMPTY && k_r > s_cur)) begin
            ok_nxt = 1'b0; st_nxt = S_UP_RD;
          end else if (rd_q == ND_EMPTY && k_r == s_cur) begin
            we = 1'b1; wd = ND_FULL_LEAF;
            bytes_nxt = bytes_r + 21'((25'd1) << s_cur);
            ok_nxt = 1'b1; st_nxt = S_UP_RD;
          end else if (rd_q == ND_EMPTY) begin
            st_nxt = S_SPLIT; lch_nxt = 2'd0;
          end else begin
            path_nxt[dep_r] = 1'b0; tried_nxt[dep_r] = 1'b0;
            node_nxt = AW'(2*node_r + 1); dep_nxt = dep_r + 1'b1; st_nxt = S_RD;
          end
        end else begin
          if (rd_q == ND_SPLIT || rd_q == ND_SPLIT_FULL) begin
            dep_nxt = dep_r + 1'b1; st_nxt = S_RD;
            if (hi_end > {1'b0, addr_r}) begin
              path_nxt[dep_r] = 1'b0; node_nxt = AW'(2*node_r + 1);
            end else begin
              path_nxt[dep_r] = 1'b1; node_nxt = AW'(2*node_r + 2);
              base_nxt = base_r + half;
            end
          end else if (rd_q == ND_FULL_LEAF && BLOCK_BASE + base_r == addr_r) begin
            we = 1'b1; wd = ND_EMPTY;
            bytes_nxt = bytes_r - 21'((25'd1) << s_cur);
            ok_nxt = 1'b1; st_nxt = S_UP_RD;
          end else begin
            ok_nxt = 1'b0; st_nxt = S_UP_RD;
          end
        end
      end
      S_SPLIT: begin
        we = 1'b1; wd = ND_EMPTY;
        wa = (lch_r == 2'd0) ? AW'(2*node_r + 1) : AW'(2*node_r + 2);
        lch_nxt = lch_r + 1'b1;
        if (lch_r != 2'd0) begin
          path_nxt[dep_r] = 1'b0; tried_nxt[dep_r] = 1'b1;
          node_nxt = AW'(2*node_r + 1); dep_nxt = dep_r + 1'b1; st_nxt = S_RD;
        end
      end
      S_UP_RD: begin
        if (dep_r == '0) begin
          stat_nxt = ok_r ? ST_OK : (cmd_r == CMD_ALLOC ? ST_NO_SPACE : ST_NOT_FOUND);
          st_nxt = S_DONE;
        end else if (cmd_r == CMD_ALLOC && !ok_r && !path_r[dep_r-1'b1]
                     && !tried_r[dep_r-1'b1]) begin
          base_nxt = base_r + (24'd1 << s_cur);
          path_nxt[dep_r-1'b1] = 1'b1;
          node_nxt = node_r + 1'b1; st_nxt = S_RD;
        end else begin
          if (path_r[dep_r-1'b1] && !ok_r) base_nxt = base_r - (24'd1 << s_cur);
          node_nxt = par; dep_nxt = dep_r - 1'b1;
          ra = AW'(2*par + 1); st_nxt = S_UP_RD2;
        end
      end
      S_UP_RD2: begin
        lch_nxt = rd_q; ra = AW'(2*node_r + 2); st_nxt = S_UP_EVAL;
      end
      S_UP_EVAL: begin
        we = 1'b1; wa = node_r; wd = merge(lch_r, rd_q); st_nxt = S_UP_RD;
      end
      S_DONE: begin
        out_valid = 1'b1; st_nxt = S_IDLE;
      end
      default: st_nxt = S_IDLE;
    endcase
  end

endmodule

@@ hw/rtl/buddy_allocator_core_checker.sv @@
// Port-level checker for the buddy allocator and its bind statement.
`include "buddy_allocator_core_defines.svh"
module buddy_allocator_core_checker
  import ba_pkg::*;
(
  input logic clk,
  input logic rst_n,
  input logic start,
  input logic busy,
  input logic out_valid,
  input logic [1:0] out_status,
  input logic [23:0] out_block_address
);
  `BA_ASSERT_IMPL(a_valid_busy, clk, rst_n, out_valid, busy)
  `BA_ASSERT_NEXT(a_done_idle, clk, rst_n, out_valid, !busy)
  `BA_ASSERT_NEXT(a_take_busy, clk, rst_n, start && !busy, busy)
  `BA_ASSERT_IMPL(a_fail_zero, clk, rst_n, out_valid && out_status != ST_OK,
                  out_block_address == 24'd0)
  `BA_ASSERT_IMPL(a_stat_rng, clk, rst_n, out_valid, out_status <= ST_NOT_FOUND)
endmodule

bind buddy_allocator_core buddy_allocator_core_checker u_chk (
  .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
  .out_valid(out_valid), .out_status(out_status),
  .out_block_address(out_block_address)
);

@@ tb/sv/tb_buddy_allocator_core.sv @@
// Self-checking testbench for the buddy allocator core with its own tree predictor.
module tb_buddy_allocator_core
  import ba_pkg::*;
();

  localparam int TREE_NODES = 65536;
  localparam int MIN_LOG2   = 5;
  localparam int MAX_LOG2   = 20;

  typedef struct {
    logic        cmd;
    logic [21:0] size;
    logic [23:0] addr;
    int          pick_live;
  } alloc_req_t;

  typedef struct {
    logic [23:0] addr;
    logic [1:0]  status;
    logic [20:0] bytes;
  } alloc_resp_t;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic        in_command;
  logic [21:0] in_alloc_size;
  logic [23:0] in_free_address;
  logic        cfg_we;
  logic [4:0]  cfg_wdata;
  logic        out_valid;
  logic [23:0] out_block_address;
  logic [1:0]  out_status;
  logic [20:0] out_bytes_in_use;

  logic [1:0]  node_mem [0:TREE_NODES-1];
  int unsigned used_bytes;
  int unsigned pool_log2;
  int unsigned found_off;
  logic [23:0] live_blocks [$];
  alloc_req_t  pending_reqs [$];
  alloc_resp_t expected_resps [$];
  alloc_req_t  drv_req;
  bit          req_out;
  int          idle_pct;
  int          errors;

  buddy_allocator_core u_top (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_command(in_command), .in_alloc_size(in_alloc_size),
    .in_free_address(in_free_address), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .out_valid(out_valid), .out_block_address(out_block_address),
    .out_status(out_status), .out_bytes_in_use(out_bytes_in_use)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #200_000_000;
    $display("Test completed with failures");
    $finish;
  end

  function automatic logic [1:0] node_get(int unsigned i);
    return (i < TREE_NODES) ? node_mem[i] : ND_EMPTY;
  endfunction

  function automatic bit node_full(logic [1:0] s);
    return s == ND_FULL_LEAF || s == ND_SPLIT_FULL;
  endfunction

  function automatic void merge_children(int unsigned i);
    logic [1:0] l;
    logic [1:0] r;
    l = node_get(2 * i + 1);
    r = node_get(2 * i + 2);
    if (node_full(l) && node_full(r)) node_mem[i] = ND_SPLIT_FULL;
    else if (l != ND_EMPTY || r != ND_EMPTY) node_mem[i] = ND_SPLIT;
    else node_mem[i] = ND_EMPTY;
  endfunction

  function automatic bit tree_alloc(int unsigned i, int unsigned s, int unsigned base,
                                    int unsigned k);
    logic [1:0] st;
    bit ok;
    st = node_get(i);
    if (node_full(st)) return 0;
    if (st == ND_SPLIT) begin
      ok = tree_alloc(2 * i + 1, s - 1, base, k);
      if (!ok) ok = tree_alloc(2 * i + 2, s - 1, base + (1 << (s - 1)), k);
      merge_children(i);
      return ok;
    end
    if (k > s) return 0;
    if (k < s) begin
      node_mem[2 * i + 1] = ND_EMPTY;
      node_mem[2 * i + 2] = ND_EMPTY;
      ok = tree_alloc(2 * i + 1, s - 1, base, k);
      merge_children(i);
      return ok;
    end
    node_mem[i] = ND_FULL_LEAF;
    used_bytes = (used_bytes + (1 << s)) & 32'h1FFFFF;
    found_off = base;
    return 1;
  endfunction

  function automatic bit tree_free(int unsigned i, int unsigned s, int unsigned base,
                                   int unsigned addr);
    logic [1:0] st;
    bit ok;
    st = node_get(i);
    if (st == ND_SPLIT || st == ND_SPLIT_FULL) begin
      if (BLOCK_BASE + base + (1 << (s - 1)) > addr)
        ok = tree_free(2 * i + 1, s - 1, base, addr);
      else
        ok = tree_free(2 * i + 2, s - 1, base + (1 << (s - 1)), addr);
      merge_children(i);
      return ok;
    end
    if (st == ND_FULL_LEAF && BLOCK_BASE + base == addr) begin
      node_mem[i] = ND_EMPTY;
      used_bytes = (used_bytes - (1 << s)) & 32'h1FFFFF;
      return 1;
    end
    return 0;
  endfunction

  function automatic void clear_tree();
    foreach (node_mem[i]) node_mem[i] = ND_EMPTY;
    used_bytes = 0;
    live_blocks.delete();
  endfunction

  function automatic void predict_request(alloc_req_t r);
    alloc_resp_t e;
    int unsigned k;
    e.addr = '0;
    if (r.cmd == CMD_ALLOC) begin
      e.status = ST_NO_SPACE;
      if (r.size <= (1 << pool_log2)) begin
        k = MIN_LOG2;
        while (k < pool_log2 && (1 << k) < r.size) k++;
        if (tree_alloc(0, pool_log2, 0, k)) begin
          e.status = ST_OK;
          e.addr = BLOCK_BASE + found_off[23:0];
          live_blocks.push_back(e.addr);
        end
      end
    end else begin
      e.status = ST_NOT_FOUND;
      if (tree_free(0, pool_log2, 0, r.addr)) begin
        e.status = ST_OK;
        foreach (live_blocks[j]) begin
          if (live_blocks[j] == r.addr) begin
            live_blocks.delete(j);
            break;
          end
        end
      end
    end
    e.bytes = used_bytes[20:0];
    expected_resps.push_back(e);
  endfunction

  task automatic report_mismatch(string field, logic [23:0] got, logic [23:0] want);
    $display("ERROR at %0t: %s got 0x%0h, expected 0x%0h", $time, field, got, want);
    errors++;
  endtask

  // Request driver: one request outstanding, inputs change on the falling edge.
  always @(negedge clk) begin
    if (rst_n && !req_out) begin
      if (pending_reqs.size() > 0 && $urandom_range(0, 99) >= idle_pct) begin
        drv_req = pending_reqs.pop_front();
        if (drv_req.pick_live != 0 && live_blocks.size() > 0)
          drv_req.addr = live_blocks[$urandom_range(0, live_blocks.size() - 1)];
        in_command      <= drv_req.cmd;
        in_alloc_size   <= drv_req.size;
        in_free_address <= drv_req.addr;
        start           <= 1'b1;
        req_out = 1'b1;
      end else begin
        start <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && start && !busy && req_out) begin
      predict_request(drv_req);
      req_out = 1'b0;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (expected_resps.size() == 0) begin
        $display("ERROR at %0t: response with no request waiting", $time);
        errors++;
      end else begin
        alloc_resp_t e;
        e = expected_resps.pop_front();
        if (out_block_address !== e.addr)
          report_mismatch("block_address", out_block_address, e.addr);
        if (out_status !== e.status)
          report_mismatch("status", {22'd0, out_status}, {22'd0, e.status});
        if (out_bytes_in_use !== e.bytes)
          report_mismatch("bytes_in_use", {3'd0, out_bytes_in_use}, {3'd0, e.bytes});
      end
    end
  end

  function automatic void add_req(logic cmd, logic [21:0] size, logic [23:0] addr,
                                  int pick_live);
    alloc_req_t r;
    r.cmd = cmd;
    r.size = size;
    r.addr = addr;
    r.pick_live = pick_live;
    pending_reqs.push_back(r);
  endfunction

  function automatic void add_random(int unsigned p, int n);
    int c;
    for (int i = 0; i < n; i++) begin
      c = $urandom_range(0, 99);
      if (c < 3) add_req(CMD_ALLOC, 22'($urandom_range(0, 22'h3FFFFF)), 24'($urandom), 0);
      else if (c < 6) add_req(CMD_ALLOC, 22'd0, 24'($urandom), 0);
      else if (c < 8) add_req(CMD_ALLOC, 22'(1 << p), 24'($urandom), 0);
      else if (c < 55)
        add_req(CMD_ALLOC,
                22'($urandom_range(1, 1 << $urandom_range(0, (p > 8) ? p - 3 : p))),
                24'($urandom), 0);
      else if (c < 90) add_req(CMD_FREE, 22'($urandom), 24'd0, 1);
      else if (c < 95)
        add_req(CMD_FREE, 22'($urandom), 24'($urandom_range(0, 24'hFFFFFF)), 0);
      else
        add_req(CMD_FREE, 22'($urandom),
                24'(BLOCK_BASE + $urandom_range(0, (1 << p) - 1)), 0);
    end
  endfunction

  task automatic wait_drained();
    @(posedge clk);
    while (pending_reqs.size() > 0 || req_out || expected_resps.size() > 0 || busy)
      @(posedge clk);
  endtask

  task automatic write_pool(logic [4:0] v);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
    clear_tree();
    pool_log2 = (v < MIN_LOG2) ? MIN_LOG2 : (v > MAX_LOG2) ? MAX_LOG2 : v;
    repeat (4) @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  initial begin
    logic [4:0] pool_cfg [9];
    pool_cfg = '{5'd5, 5'd0, 5'd31, 5'd8, 5'd12, 5'd20, 5'd10, 5'd6, 5'd9};
    errors = 0;
    req_out = 1'b0;
    idle_pct = 7;
    rst_n = 1'b0;
    start = 1'b0;
    in_command = CMD_ALLOC;
    in_alloc_size = '0;
    in_free_address = '0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    clear_tree();
    pool_log2 = MAX_LOG2;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed requests on the full-size pool left by reset.
    add_req(CMD_ALLOC, 22'd0, 24'd0, 0);
    add_req(CMD_ALLOC, 22'd1, 24'd0, 0);
    add_req(CMD_ALLOC, 22'd32, 24'd0, 0);
    add_req(CMD_ALLOC, 22'd33, 24'd0, 0);
    add_req(CMD_ALLOC, 22'd4096, 24'd0, 0);
    add_req(CMD_ALLOC, 22'h100000, 24'd0, 0);
    add_req(CMD_ALLOC, 22'h3FFFFF, 24'hFFFFFF, 0);
    add_req(CMD_ALLOC, 22'h100001, 24'd0, 0);
    add_req(CMD_FREE, 22'h3FFFFF, 24'd0, 0);
    add_req(CMD_FREE, 22'd0, 24'hFFFFFF, 0);
    add_req(CMD_FREE, 22'd0, BLOCK_BASE + 24'd32, 0);
    add_req(CMD_FREE, 22'd0, BLOCK_BASE + 24'd16, 0);
    for (int i = 0; i < 4; i++) add_req(CMD_FREE, 22'd0, 24'd0, 1);
    add_req(CMD_FREE, 22'd0, BLOCK_BASE, 0);
    add_req(CMD_ALLOC, 22'h080001, 24'd0, 0);
    add_req(CMD_ALLOC, 22'h080000, 24'd0, 0);
    add_req(CMD_FREE, 22'd0, 24'd0, 1);
    add_req(CMD_ALLOC, 22'h100000, 24'd0, 0);
    add_req(CMD_ALLOC, 22'd1, 24'd0, 0);
    add_req(CMD_FREE, 22'd0, BLOCK_BASE, 0);
    add_random(pool_log2, 150);
    wait_drained();

    foreach (pool_cfg[ph]) begin
      idle_pct = (ph < 3) ? 7 : (ph < 6) ? 70 : 0;
      write_pool(pool_cfg[ph]);
      add_random(pool_log2, (pool_log2 == MAX_LOG2) ? 100 : 190);
      wait_drained();
    end

    repeat (300) @(posedge clk);
    if (errors == 0 && expected_resps.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
